### hdl/audio_ring_free_space_tracker_defines.svh
// assertion macros shared by the ring tracker modules
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef AUDIO_RING_FREE_SPACE_TRACKER_DEFINES_SVH
`define AUDIO_RING_FREE_SPACE_TRACKER_DEFINES_SVH

// same-cycle implication
`define ARFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/arft_pkg.sv
// shared types, constants and helper functions for the ring tracker
// no dependencies
`default_nettype none

package arft_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned MOD_STEPS = SIZE_W;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [SIZE_W-1:0] RING_DEFAULT = 17'd8192;
  localparam logic [SIZE_W-1:0] RING_MAX     = 17'd65536;

  localparam logic CFG_RING_SIZE    = 1'b0;
  localparam logic CFG_HAS_CONSUMER = 1'b1;

  typedef enum logic [1:0] {
    OP_SYNC  = 2'd0,
    OP_QUEUE = 2'd1,
    OP_QUERY = 2'd2,
    OP_RESET = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SYNC_MOD,
    ST_QCHECK,
    ST_ADD_MOD,
    ST_FIRST_MOD,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] numer;
    logic [SIZE_W-1:0] denom;
  } mod_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] rem;
  } mod_rsp_t;

  // zero selects the default size, anything above the maximum saturates
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] s;
    s = raw;
    if (raw == '0) begin
      s = RING_DEFAULT;
    end else if (raw > RING_MAX) begin
      s = RING_MAX;
    end
    return s;
  endfunction

  // size minus one minus queued, floored at zero; size minus one when unarmed
  function automatic logic [DATA_W-1:0] free_space(input logic [SIZE_W-1:0] size,
                                                   input logic              armed,
                                                   input logic [DATA_W-1:0] queued);
    logic [SIZE_W-1:0] lim;
    logic [DATA_W-1:0] res;
    lim = size - 17'd1;
    if (!armed) begin
      res = lim[DATA_W-1:0];
    end else if ({1'b0, queued} >= lim) begin
      res = '0;
    end else begin
      res = lim[DATA_W-1:0] - queued;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/arft_mod_unit.sv
// shared restoring remainder unit, one quotient bit per cycle
// depends on arft_pkg and the assertion macro header
`default_nettype none

module arft_mod_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  arft_pkg::mod_req_t     req_i,
  output arft_pkg::mod_rsp_t     rsp_o
);
  import arft_pkg::*;
  `include "audio_ring_free_space_tracker_defines.svh"

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [SIZE_W-1:0]    numer_q, numer_d;
  logic [SIZE_W-1:0]    denom_q, denom_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      trial_sub;

  assign trial     = {rem_q, numer_q[SIZE_W-1]};
  assign trial_sub = trial - {1'b0, denom_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    numer_d = numer_q;
    denom_d = denom_q;
    rem_d   = rem_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      numer_d = req_i.numer;
      denom_d = req_i.denom;
      rem_d   = '0;
    end else if (busy_q) begin
      numer_d = {numer_q[SIZE_W-2:0], 1'b0};
      rem_d   = (trial >= {1'b0, denom_q}) ? trial_sub[SIZE_W-1:0] : trial[SIZE_W-1:0];
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    numer_q <= numer_d;
    denom_q <= denom_d;
    rem_q   <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[DATA_W-1:0];

  `ARFT_ASSERT_NEXT(a_done_single, done_q, !done_q, "remainder done held for more than a cycle")
  `ARFT_ASSERT_NOW(a_rem_below_denom, done_q, rem_q < denom_q, "remainder not below divisor")

endmodule

`default_nettype wire

### hdl/audio_ring_free_space_tracker.sv
// top level of the ring tracker: sequencer, tracking state, config and output register
// depends on arft_pkg, arft_mod_unit and the assertion macro header
`default_nettype none

// Producer-side accounting for a circular audio buffer. Each input word carries an
// operation (sync, queue, free query or reset), a length and the consumer position,
// and gives exactly one result word: status, free bytes, write start and the arm pulse.
// All wrap arithmetic goes through one shared restoring remainder unit that produces
// one bit per cycle. A reset op, a zero or one byte queue, or a sync or query with
// nothing to do goes from decode straight to the finish state; a sync or query
// that runs the unit, or a first queue, runs the unit once. A queue on an armed ring
// first runs the unit for the consumer advance when the position is valid, then
// checks the room: a refusal goes straight to the finish state, an accepted
// request runs the unit again for the new write offset. The block takes one word at a
// time: in_stall_o is high from acceptance until the result is loaded into the output
// register, so the next word can be taken in the cycle after that load, even while
// that result still waits downstream. Configuration writes are always taken and
// should only be issued with nothing in flight.
module audio_ring_free_space_tracker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write channel
  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic                        cfg_index_i,
  input  wire logic [arft_pkg::SIZE_W-1:0] cfg_data_i,
  // input words
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [arft_pkg::DATA_W-1:0] length_i,
  input  wire logic [arft_pkg::DATA_W-1:0] consumer_position_i,
  // result words
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic                        status_o,
  output      logic [arft_pkg::DATA_W-1:0] free_bytes_o,
  output      logic [arft_pkg::DATA_W-1:0] write_start_o,
  output      logic                        arm_pulse_o
);
  import arft_pkg::*;
  `include "audio_ring_free_space_tracker_defines.svh"

  // sequencer and latched input word
  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [DATA_W-1:0] len_q, len_d;
  logic [DATA_W-1:0] pos_q, pos_d;
  logic              sync_neg_q, sync_neg_d;

  // per-word result scratch
  logic              status_q, status_d;
  logic              arm_q, arm_d;
  logic [DATA_W-1:0] start_q, start_d;

  // tracking state
  logic [DATA_W-1:0] write_offset_q, write_offset_d;
  logic [DATA_W-1:0] queued_q, queued_d;
  logic [DATA_W-1:0] last_q, last_d;
  logic              armed_q, armed_d;

  // configuration
  logic [SIZE_W-1:0] ring_size_q;
  logic              has_consumer_q;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_status_q, out_status_d;
  logic [DATA_W-1:0] out_free_q, out_free_d;
  logic [DATA_W-1:0] out_start_q, out_start_d;
  logic              out_arm_q, out_arm_d;

  // shared remainder unit
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;

  // helpers
  logic [SIZE_W-1:0] size;
  logic [DATA_W-1:0] len_even;
  logic              pos_in_range;
  logic              sync_ok;
  logic [SIZE_W:0]   adv;
  logic [SIZE_W:0]   adv_neg;
  logic [SIZE_W-1:0] adv_mag;
  logic [SIZE_W-1:0] played_wrap;
  logic [DATA_W-1:0] played;
  logic [DATA_W-1:0] free_now;
  logic [SIZE_W-1:0] add_sum;

  arft_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign size         = eff_size(ring_size_q);
  assign len_even     = {len_q[DATA_W-1:1], 1'b0};
  assign pos_in_range = {1'b0, pos_q} < size;
  assign sync_ok      = armed_q && has_consumer_q && pos_in_range;

  // consumer advance pos + size - last, may be negative after a size change
  assign adv     = {2'b00, pos_q} + {1'b0, size} - {2'b00, last_q};
  assign adv_neg = ~adv + 1'b1;
  assign adv_mag = adv[SIZE_W] ? adv_neg[SIZE_W-1:0] : adv[SIZE_W-1:0];

  // true modulo from the remainder of the magnitude
  assign played_wrap = size - {1'b0, mod_rsp.rem};
  always_comb begin
    if (!sync_neg_q) begin
      played = mod_rsp.rem;
    end else if (mod_rsp.rem == '0) begin
      played = '0;
    end else begin
      played = played_wrap[DATA_W-1:0];
    end
  end

  assign free_now = free_space(size, armed_q, queued_q);
  assign add_sum  = {1'b0, write_offset_q} + {1'b0, len_even};

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    len_d          = len_q;
    pos_d          = pos_q;
    sync_neg_d     = sync_neg_q;
    status_d       = status_q;
    arm_d          = arm_q;
    start_d        = start_q;
    write_offset_d = write_offset_q;
    queued_d       = queued_q;
    last_d         = last_q;
    armed_d        = armed_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_status_d   = out_status_q;
    out_free_d     = out_free_q;
    out_start_d    = out_start_q;
    out_arm_d      = out_arm_q;
    mod_req        = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_e'(op_i);
          len_d   = length_i;
          pos_d   = consumer_position_i;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        status_d = 1'b0;
        arm_d    = 1'b0;
        start_d  = write_offset_q;
        state_d  = ST_FINISH;
        case (op_q)
          OP_RESET: begin
            write_offset_d = '0;
            queued_d       = '0;
            last_d         = '0;
            armed_d        = 1'b0;
          end
          OP_SYNC, OP_QUERY: begin
            if (sync_ok) begin
              mod_req.start = 1'b1;
              mod_req.numer = adv_mag;
              mod_req.denom = size;
              sync_neg_d    = adv[SIZE_W];
              state_d       = ST_SYNC_MOD;
            end
          end
          OP_QUEUE: begin
            if (len_q == '0) begin
              status_d = 1'b1;
            end else if (len_even == '0) begin
              // length one: accepted, nothing to do
              status_d = 1'b0;
            end else if (!armed_q) begin
              mod_req.start = 1'b1;
              mod_req.numer = {1'b0, len_even};
              mod_req.denom = size;
              state_d       = ST_FIRST_MOD;
            end else if (sync_ok) begin
              mod_req.start = 1'b1;
              mod_req.numer = adv_mag;
              mod_req.denom = size;
              sync_neg_d    = adv[SIZE_W];
              state_d       = ST_SYNC_MOD;
            end else begin
              state_d = ST_QCHECK;
            end
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end

      ST_SYNC_MOD: begin
        if (mod_rsp.done) begin
          last_d = pos_q;
          if (played >= queued_q) begin
            // underrun: re-seat at the even-aligned consumer
            queued_d       = '0;
            write_offset_d = {pos_q[DATA_W-1:1], 1'b0};
          end else begin
            queued_d = queued_q - played;
          end
          state_d = (op_q == OP_QUEUE) ? ST_QCHECK : ST_FINISH;
        end
      end

      ST_QCHECK: begin
        start_d = write_offset_q;
        if (len_even > free_now) begin
          status_d = 1'b1;
          state_d  = ST_FINISH;
        end else begin
          mod_req.start = 1'b1;
          mod_req.numer = add_sum;
          mod_req.denom = size;
          state_d       = ST_ADD_MOD;
        end
      end

      ST_ADD_MOD: begin
        if (mod_rsp.done) begin
          write_offset_d = mod_rsp.rem;
          queued_d       = queued_q + len_even;
          state_d        = ST_FINISH;
        end
      end

      ST_FIRST_MOD: begin
        if (mod_rsp.done) begin
          start_d        = '0;
          write_offset_d = mod_rsp.rem;
          queued_d       = len_even;
          armed_d        = 1'b1;
          arm_d          = 1'b1;
          last_d         = (has_consumer_q && pos_in_range) ? pos_q : '0;
          state_d        = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // load only when the output register is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_free_d   = free_now;
          out_start_d  = (op_q == OP_QUEUE) ? start_q : write_offset_q;
          out_arm_d    = arm_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      write_offset_q <= '0;
      queued_q       <= '0;
      last_q         <= '0;
      armed_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      write_offset_q <= write_offset_d;
      queued_q       <= queued_d;
      last_q         <= last_d;
      armed_q        <= armed_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q    <= RING_DEFAULT;
      has_consumer_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RING_SIZE: begin
          ring_size_q <= cfg_data_i;
        end
        CFG_HAS_CONSUMER: begin
          has_consumer_q <= cfg_data_i[0];
        end
        default: begin
          ring_size_q <= ring_size_q;
        end
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    len_q        <= len_d;
    pos_q        <= pos_d;
    sync_neg_q   <= sync_neg_d;
    status_q     <= status_d;
    arm_q        <= arm_d;
    start_q      <= start_d;
    out_status_q <= out_status_d;
    out_free_q   <= out_free_d;
    out_start_q  <= out_start_d;
    out_arm_q    <= out_arm_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign free_bytes_o  = out_free_q;
  assign write_start_o = out_start_q;
  assign arm_pulse_o   = out_arm_q;

  `ARFT_ASSERT_NOW(a_mod_start_free, mod_req.start, !mod_rsp.busy, "remainder unit started while busy")
  `ARFT_ASSERT_NEXT(a_accept_decode, in_valid_i && !in_stall_o, state_q == ST_DECODE, "accepted word not decoded")
  `ARFT_ASSERT_NOW(a_disarm_on_reset_op, $fell(armed_q), op_q == OP_RESET, "armed flag cleared without a reset op")
  `ARFT_ASSERT_NOW(a_arm_implies_ok, out_valid_q && out_arm_q, !out_status_q, "arming word reported as rejected")

endmodule

`default_nettype wire

### dv/tb.sv
// self-checking testbench for audio_ring_free_space_tracker
// depends on arft_pkg and the tracker rtl; predicts each result word from its own ring accounting

`default_nettype none

module tb;
  import arft_pkg::*;

  // ---------------------------------------------------------------------------
  // word types: one request word in, one result word out
  // ---------------------------------------------------------------------------
  typedef struct packed {
    op_e         op;
    logic [15:0] length;
    logic [15:0] position;
  } ring_req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] free_bytes;
    logic [15:0] write_start;
    logic        arm_pulse;
  } ring_result_t;

  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned HOLD_AT       = 300;      // words accepted before the long hold-off
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned LIMIT_TIME    = 20000000; // far above the slowest run
  localparam int unsigned PHASES        = 7;

  // ---------------------------------------------------------------------------
  // clock, reset and dut ports, the inputs all known from time zero
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [16:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic [15:0] length_i = '0;
  logic [15:0] consumer_position_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        status_o;
  logic [15:0] free_bytes_o;
  logic [15:0] write_start_o;
  logic        arm_pulse_o;

  always #10 clk_i = ~clk_i;

  audio_ring_free_space_tracker dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .op_i                (op_i),
    .length_i            (length_i),
    .consumer_position_i (consumer_position_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .free_bytes_o        (free_bytes_o),
    .write_start_o       (write_start_o),
    .arm_pulse_o         (arm_pulse_o)
  );

  // ---------------------------------------------------------------------------
  // tracking model: own copy of the registers and the producer state
  // ---------------------------------------------------------------------------
  logic [16:0] ring_raw = RING_DEFAULT;
  logic        consumer_en = 1'b1;
  logic [15:0] trk_wr_ofs = '0;
  logic [15:0] trk_queued = '0;
  logic [15:0] trk_consumer = '0;
  logic        trk_armed = 1'b0;

  // a written zero means the default ring, anything past the maximum saturates
  function automatic int unsigned ring_bytes(input logic [16:0] raw);
    if (raw == '0) return 32'(RING_DEFAULT);
    if (raw > RING_MAX) return 32'(RING_MAX);
    return 32'(raw);
  endfunction

  function automatic int unsigned room_left(input int unsigned size);
    if (!trk_armed) return size - 1;
    if (trk_queued >= size - 1) return 0;
    return size - 1 - trk_queued;
  endfunction

  // consumer advance is a true modulo, so stale offsets after a ring resize still wrap
  function automatic void consumer_sync(input int unsigned pos, input int unsigned size);
    int          delta;
    int unsigned played;
    if (!trk_armed || !consumer_en || pos >= size) return;
    delta = pos + size - trk_consumer;
    if (delta < 0) begin
      played = -delta;
      played = size - (played % size);
      if (played == size) played = 0;
    end else begin
      played = delta;
      played = played % size;
    end
    trk_consumer = pos[15:0];
    if (played >= trk_queued) begin
      // underrun: restart at the consumer, rounded down to an even byte
      trk_queued = '0;
      trk_wr_ofs = pos[15:0] & 16'hFFFE;
    end else begin
      trk_queued = 16'(trk_queued - played);
    end
  endfunction

  function automatic ring_result_t track_word(input ring_req_t req);
    ring_result_t res;
    int unsigned  size;
    int unsigned  len;
    int unsigned  start;
    res  = '0;
    size = ring_bytes(ring_raw);
    len  = 32'(req.length);
    case (req.op)
      OP_SYNC, OP_QUERY: consumer_sync(32'(req.position), size);
      OP_RESET: begin
        trk_wr_ofs   = '0;
        trk_queued   = '0;
        trk_consumer = '0;
        trk_armed    = 1'b0;
      end
      default: ;
    endcase
    start = 32'(trk_wr_ofs);
    if (req.op == OP_QUEUE) begin
      if (len == 0) begin
        res.status = 1'b1;
      end else begin
        len = len & 32'hFFFE;
        if (len != 0) begin
          if (!trk_armed) begin
            // first queue arms the consumer and skips the room check
            start         = 0;
            trk_wr_ofs    = 16'(len % size);
            trk_queued    = len[15:0];
            trk_armed     = 1'b1;
            res.arm_pulse = 1'b1;
            trk_consumer  = (consumer_en && req.position < size) ? req.position : '0;
          end else begin
            consumer_sync(32'(req.position), size);
            start = 32'(trk_wr_ofs);
            if (len > room_left(size)) begin
              res.status = 1'b1;
            end else begin
              trk_wr_ofs = 16'((trk_wr_ofs + len) % size);
              trk_queued = trk_queued + len[15:0];
            end
          end
        end
      end
    end
    res.free_bytes  = 16'(room_left(size));
    res.write_start = start[15:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // idle lengths: mostly none or short, a few long, with calm stretches
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(40, 120);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  ring_req_t    pending_words[$];
  ring_result_t expected_results[$];
  ring_req_t    drive_word;
  ring_result_t due_result;
  ring_result_t seen_result;
  logic         word_taken = 1'b0;
  int unsigned  in_gap = 0;
  int unsigned  in_calm = 0;
  int unsigned  out_calm = 0;
  int unsigned  stall_left = 0;
  int unsigned  hold_left = 0;
  logic         hold_done = 1'b0;
  int unsigned  words_in = 0;
  int unsigned  results_seen = 0;
  int unsigned  rejects = 0;
  int unsigned  arms = 0;
  int unsigned  fail_cnt = 0;

  // ---------------------------------------------------------------------------
  // driver: next word goes out on the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || word_taken) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        drive_word = pending_words.pop_front();
        op_i                <= drive_word.op;
        length_i            <= drive_word.length;
        consumer_position_i <= drive_word.position;
        in_valid_i          <= 1'b1;
        in_gap = idle_len(in_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result stall: random gaps plus one long hold-off so the input backs up
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!hold_done && words_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = idle_len(out_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each accepted word, checks each accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid_i && !in_stall_o;
      // check first, a result can never belong to a word taken on the same edge
      if (out_valid_o && !out_stall_i) begin
        seen_result.status      = status_o;
        seen_result.free_bytes  = free_bytes_o;
        seen_result.write_start = write_start_o;
        seen_result.arm_pulse   = arm_pulse_o;
        results_seen = results_seen + 1;
        if (expected_results.size() == 0) begin
          fail_cnt = fail_cnt + 1;
          if (fail_cnt <= 10)
            $display("tb: result word %0d arrived with nothing expected", results_seen);
        end else begin
          due_result = expected_results.pop_front();
          if (seen_result.status !== due_result.status ||
              seen_result.free_bytes !== due_result.free_bytes ||
              seen_result.write_start !== due_result.write_start ||
              seen_result.arm_pulse !== due_result.arm_pulse) begin
            fail_cnt = fail_cnt + 1;
            if (fail_cnt <= 10)
              $display({"tb: result word %0d (exp/got) status %0d/%0d free %0d/%0d",
                        " start %0d/%0d arm %0d/%0d"},
                       results_seen, due_result.status, seen_result.status,
                       due_result.free_bytes, seen_result.free_bytes,
                       due_result.write_start, seen_result.write_start,
                       due_result.arm_pulse, seen_result.arm_pulse);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        drive_word.op       = op_e'(op_i);
        drive_word.length   = length_i;
        drive_word.position = consumer_position_i;
        due_result = track_word(drive_word);
        expected_results.push_back(due_result);
        words_in = words_in + 1;
        if (due_result.status) rejects = rejects + 1;
        if (due_result.arm_pulse) arms = arms + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_word(input op_e op, input int unsigned len, input int unsigned pos);
    ring_req_t w;
    w.op       = op;
    w.length   = len[15:0];
    w.position = pos[15:0];
    pending_words.push_back(w);
  endtask

  // mostly a consumer walking the ring with producer requests around it, some noise
  task automatic add_random(input int count, input int unsigned size);
    op_e         op;
    int unsigned r;
    int unsigned cur;
    int unsigned len;
    int unsigned pos;
    cur = 0;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) op = OP_SYNC;
      else if (r < 75) op = OP_QUEUE;
      else if (r < 96) op = OP_QUERY;
      else op = OP_RESET;
      r = $urandom_range(0, 99);
      if (r < 5 && size < 65536) begin
        pos = $urandom_range(size, 65535);
      end else if (r < 12) begin
        pos = $urandom_range(0, 65535);
      end else begin
        if (r < 60) cur = (cur + $urandom_range(0, size / 16 + 1)) % size;
        else if (r < 90) cur = (cur + $urandom_range(0, size - 1)) % size;
        pos = cur;
      end
      r = $urandom_range(0, 99);
      if (r < 45) len = $urandom_range(1, size / 4 + 2);
      else if (r < 60) len = $urandom_range(0, 3);
      else if (r < 80) len = $urandom_range(size / 2, size);
      else len = $urandom_range(0, 65535);
      if (len > 65535) len = 65535;
      add_word(op, len, pos);
    end
  endtask

  // block is idle once every word is in and every result is out, plus its latency
  task automatic settle();
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [16:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_RING_SIZE) ring_raw = data;
    else consumer_en = data[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [16:0] raw;
    logic        cons;
    int          count;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words on the reset ring of 8192 bytes with a consumer present
    add_word(OP_QUERY, 0, 0);              // unarmed free space
    add_word(OP_SYNC, 16'hFFFF, 100);      // sync while unarmed does nothing
    add_word(OP_QUEUE, 0, 0);              // zero length is refused
    add_word(OP_QUEUE, 1, 0);              // length one rounds away to nothing
    add_word(OP_QUEUE, 1001, 9000);        // first queue, out-of-range position latches 0
    add_word(OP_QUEUE, 16'hFFFF, 0);       // far more than the room left
    add_word(OP_SYNC, 0, 16'hFFFF);        // out-of-range position ignored
    add_word(OP_SYNC, 0, 200);
    add_word(OP_QUEUE, 2000, 200);
    add_word(OP_QUERY, 0, 1200);
    add_word(OP_SYNC, 0, 3000);            // everything played, underrun
    add_word(OP_SYNC, 0, 3001);            // underrun on an odd consumer
    add_word(OP_QUEUE, 8190, 3001);        // fills the ring and wraps
    add_word(OP_QUEUE, 2, 3001);           // no room left
    add_word(OP_SYNC, 0, 0);               // consumer wraps past the end
    add_word(OP_RESET, 16'hFFFF, 16'hFFFF);
    add_word(OP_QUEUE, 16'hFFFE, 5);       // first queue larger than the ring
    add_word(OP_QUERY, 0, 4000);
    add_word(OP_SYNC, 0, 2);
    add_word(OP_QUEUE, 16'hAAAA, 16'h5555);
    add_word(OP_RESET, 0, 0);
    add_word(OP_QUEUE, 4000, 8191);        // left armed across the next resize

    // random phases: a two-byte ring, saturated, default via zero, largest, odd sizes, a 64-byte ring
    for (int p = 0; p < PHASES; p++) begin
      cons = 1'b1;
      case (p)
        0: begin raw = 17'd2;      count = 60;  end
        1: begin raw = 17'h1FFFF;  count = 180; end
        2: begin raw = '0;         count = 80;  cons = 1'b0; end
        3: begin raw = RING_MAX;   count = 120; end
        4: begin raw = 17'($urandom_range(3, 600)); count = 200; end
        5: begin
          raw   = 17'($urandom_range(0, 131071));
          cons  = 1'($urandom_range(0, 1));
          count = 120;
        end
        default: begin raw = 17'd64; count = 140; end
      endcase
      settle();
      cfg_write(CFG_RING_SIZE, raw);
      cfg_write(CFG_HAS_CONSUMER, {16'd0, cons});
      add_random(count, ring_bytes(raw));
    end
    settle();

    $display("tb: %0d words over %0d ring settings, %0d results checked",
             words_in, PHASES + 1, results_seen);
    $display("tb: %0d requests refused, %0d arm pulses, one long output hold-off",
             rejects, arms);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", fail_cnt);
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_TIME);
    $display("tb: timed out with %0d results outstanding", expected_results.size());
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+hdl
hdl/arft_pkg.sv
hdl/arft_mod_unit.sv
hdl/audio_ring_free_space_tracker.sv
dv/tb.sv
